@@ hdl/per_thread_stream_pool_binder_defines.svh @@
// Assertion macros for the stream pool binder checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef PER_THREAD_STREAM_POOL_BINDER_DEFINES_SVH
`define PER_THREAD_STREAM_POOL_BINDER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define PSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/psb_pkg.sv @@
// Types and codes for the per-thread stream pool binder.
// No dependencies; used by every module of the block except psb_ffs.
package psb_pkg;

    localparam int KIND_W   = 3;
    localparam int THREAD_W = 4;
    localparam int SIDX_W   = 5;
    localparam int STAT_W   = 3;
    localparam int USES_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int MODE_W   = 2;

    localparam logic [KIND_W-1:0] KIND_ACQUIRE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SUBMIT   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SYNC     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SHUTDOWN = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_SHUT    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOFREE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNBOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_PENDING = 3'd4;

    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOUND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [THREAD_W-1:0] thread;
    } t_item;

    typedef struct packed {
        logic [SIDX_W-1:0]  stream_index;
        logic               bound;
        logic [STAT_W-1:0]  status;
        logic [USES_W-1:0]  use_total;
        logic [COUNT_W-1:0] binding_count;
    } t_result;

endpackage

@@ hdl/psb_ffs.sv @@
// Lowest-set-bit priority encoder over the free-stream mask.
// Standalone; instantiated by psb_core.
module psb_ffs #(
    parameter int W  = 32,
    parameter int IW = 5
) (
    input  logic [W-1:0]  i_mask,
    output logic          o_found,
    output logic [IW-1:0] o_index
);

    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        // scan from the top so the lowest set bit wins
        for (int i = W - 1; i >= 0; i--) begin
            if (i_mask[i]) begin
                o_found = 1'b1;
                o_index = IW'(i);
            end
        end
    end

endmodule

@@ hdl/psb_core.sv @@
// Binding tables, stream state and the per-item decision logic.
// Depends on psb_pkg and psb_ffs.
module psb_core #(
    parameter int STREAM_COUNT = 32,
    parameter int THREAD_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  psb_pkg::t_item    i_item,
    output psb_pkg::t_result  o_result
);

    localparam int SW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;
    localparam int TW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int IW = (TW > psb_pkg::THREAD_W) ? TW : psb_pkg::THREAD_W;

    logic                         r_bind_valid [THREAD_COUNT];
    logic [psb_pkg::SIDX_W-1:0]   r_bind_stream [THREAD_COUNT];
    logic [psb_pkg::MODE_W-1:0]   r_mode [STREAM_COUNT];
    logic [psb_pkg::USES_W-1:0]   r_uses [STREAM_COUNT];
    logic [STREAM_COUNT-1:0]      r_free_mask;
    logic                         r_alive;
    logic [psb_pkg::COUNT_W-1:0]  r_count;

    logic [STREAM_COUNT-1:0]      n_free_mask;
    logic                         n_alive;
    logic [psb_pkg::COUNT_W-1:0]  n_count;

    logic [IW-1:0]                w_tid_ext;
    logic [TW-1:0]                w_tidx;
    logic                         w_valid_thread;
    logic                         w_has;
    logic [SW-1:0]                w_s;
    logic                         w_ffs_found;
    logic [SW-1:0]                w_ffs_idx;
    logic [SW-1:0]                w_rd_addr;
    logic [psb_pkg::USES_W-1:0]   w_uses_rd;
    logic [psb_pkg::USES_W-1:0]   w_uses_new;
    logic                         w_acq_ok;
    logic                         w_rel_ok;
    logic                         w_sub_ok;
    logic                         w_sync_ok;
    logic                         w_shut;
    logic [psb_pkg::STAT_W-1:0]   w_status;
    logic                         w_bound_after;
    logic [SW-1:0]                w_idx_after;

    psb_ffs #(
        .W  (STREAM_COUNT),
        .IW (SW)
    ) u_ffs (
        .i_mask  (r_free_mask),
        .o_found (w_ffs_found),
        .o_index (w_ffs_idx)
    );

    always_comb begin
        w_tid_ext      = IW'(i_item.thread);
        w_valid_thread = (32'(i_item.thread) < THREAD_COUNT);
        // out-of-range threads read entry zero, gated off by w_valid_thread
        w_tidx         = w_valid_thread ? w_tid_ext[TW-1:0] : '0;
        w_has          = w_valid_thread && r_bind_valid[w_tidx];
        w_s            = r_bind_stream[w_tidx][SW-1:0];
        w_rd_addr      = w_has ? w_s : w_ffs_idx;
        w_uses_rd      = r_uses[w_rd_addr];

        w_acq_ok  = 1'b0;
        w_rel_ok  = 1'b0;
        w_sub_ok  = 1'b0;
        w_sync_ok = 1'b0;
        w_shut    = 1'b0;
        w_status  = psb_pkg::ST_OK;

        if (i_item.kind == psb_pkg::KIND_SHUTDOWN) begin
            w_shut = 1'b1;
        end else if (!w_valid_thread) begin
            w_status = psb_pkg::ST_UNBOUND;
        end else begin
            case (i_item.kind)
                psb_pkg::KIND_ACQUIRE: begin
                    if (!r_alive) begin
                        w_status = psb_pkg::ST_SHUT;
                    end else if (!w_has) begin
                        if (!w_ffs_found) begin
                            w_status = psb_pkg::ST_NOFREE;
                        end else begin
                            w_acq_ok = 1'b1;
                        end
                    end
                end
                psb_pkg::KIND_RELEASE: begin
                    if (w_has) begin
                        if (r_mode[w_s] == psb_pkg::MODE_ACTIVE) begin
                            w_status = psb_pkg::ST_PENDING;
                        end else begin
                            w_rel_ok = 1'b1;
                        end
                    end
                end
                psb_pkg::KIND_SUBMIT: begin
                    if (!w_has) begin
                        w_status = psb_pkg::ST_UNBOUND;
                    end else begin
                        w_sub_ok = 1'b1;
                    end
                end
                psb_pkg::KIND_SYNC: begin
                    w_sync_ok = w_has;
                end
                default: begin
                    // query and unused kinds only report
                end
            endcase
        end

        w_uses_new    = w_sub_ok ? psb_pkg::USES_W'(w_uses_rd + 32'd1) : w_uses_rd;
        w_bound_after = w_acq_ok || (w_has && !w_rel_ok);
        w_idx_after   = w_acq_ok ? w_ffs_idx : w_s;

        n_free_mask = r_free_mask;
        n_count     = r_count;
        n_alive     = r_alive && !w_shut;
        if (w_acq_ok) begin
            n_free_mask[w_ffs_idx] = 1'b0;
            n_count = psb_pkg::COUNT_W'(r_count + 5'd1);
        end else if (w_rel_ok) begin
            n_free_mask[w_s] = 1'b1;
            n_count = psb_pkg::COUNT_W'(r_count - 5'd1);
        end

        o_result.stream_index  = w_bound_after ? psb_pkg::SIDX_W'(w_idx_after) : '0;
        o_result.bound         = w_bound_after;
        o_result.status        = w_status;
        o_result.use_total     = w_bound_after ? w_uses_new : '0;
        o_result.binding_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_mask <= '1;
            r_alive     <= 1'b1;
            r_count     <= '0;
            for (int t = 0; t < THREAD_COUNT; t++) begin
                r_bind_valid[t] <= 1'b0;
            end
            for (int s = 0; s < STREAM_COUNT; s++) begin
                r_mode[s] <= psb_pkg::MODE_FREE;
                r_uses[s] <= '0;
            end
        end else if (i_valid) begin
            r_free_mask <= n_free_mask;
            r_alive     <= n_alive;
            r_count     <= n_count;
            if (w_acq_ok) begin
                r_bind_valid[w_tidx]  <= 1'b1;
                r_bind_stream[w_tidx] <= psb_pkg::SIDX_W'(w_ffs_idx);
                r_mode[w_ffs_idx]     <= psb_pkg::MODE_BOUND;
            end
            if (w_rel_ok) begin
                r_bind_valid[w_tidx] <= 1'b0;
                r_mode[w_s]          <= psb_pkg::MODE_FREE;
            end
            if (w_sub_ok) begin
                r_mode[w_s] <= psb_pkg::MODE_ACTIVE;
                r_uses[w_s] <= w_uses_new;
            end
            if (w_sync_ok) begin
                r_mode[w_s] <= psb_pkg::MODE_BOUND;
            end
        end
    end

endmodule

@@ hdl/per_thread_stream_pool_binder.sv @@
// Top level of the per-thread stream pool binder: input and result registers.
// Depends on psb_pkg and psb_core.
//
//  channel   ports                      transfer when
//  request   start, busy, i_item        start && !busy at a rising edge
//  result    o_valid, o_result          o_valid high for one cycle
//
// One request per cycle; its result passes the input register, then the table
// lookup, lowest-free-stream encode and update, then the result register, and
// is then on the ports.
// busy is high only while reset is asserted; reset clears all bindings,
// frees every stream, zeroes the use counters and reopens the pool.
// Results cannot be stalled: each is shown for exactly one cycle.
module per_thread_stream_pool_binder #(
    parameter int STREAM_COUNT = 32,
    parameter int THREAD_COUNT = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  psb_pkg::t_item    i_item,
    output logic              o_valid,
    output psb_pkg::t_result  o_result
);

    logic              r_in_valid;
    psb_pkg::t_item    r_item;
    logic              r_valid;
    psb_pkg::t_result  r_result;
    psb_pkg::t_result  w_result;

    assign busy = !i_rst_n;

    psb_core #(
        .STREAM_COUNT (STREAM_COUNT),
        .THREAD_COUNT (THREAD_COUNT)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_item   (r_item),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
            r_valid    <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= i_item;
        r_result <= w_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ hdl/psb_checker.sv @@
// Port-level checks for the stream pool binder, bound to the top level.
// Depends on psb_pkg and per_thread_stream_pool_binder_defines.svh.
`include "per_thread_stream_pool_binder_defines.svh"

module psb_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  psb_pkg::t_item    i_item,
    input  logic              o_valid,
    input  psb_pkg::t_result  o_result
);

    logic w_xfer;
    assign w_xfer = start && !busy;

    // every request transfer yields exactly one result, after the input and result registers
    `PSB_ASSERT_NEXT(a_result_follows, w_xfer, ##1 o_valid, "missing result")
    `PSB_ASSERT_NEXT(a_no_spurious, !w_xfer, ##1 !o_valid, "result without request")

    // a thread without a stream reports zero index and zero uses
    `PSB_ASSERT(a_unbound_zero, o_valid && !o_result.bound |-> o_result.stream_index == 5'd0 && o_result.use_total == 32'd0, "unbound result not zero")

    // refused for no free stream or not bound means the thread holds nothing
    `PSB_ASSERT(a_refused_unbound, o_valid && (o_result.status == psb_pkg::ST_NOFREE || o_result.status == psb_pkg::ST_UNBOUND) |-> !o_result.bound, "refused thread reported bound")

    // back-to-back results move the binding count by at most one
    `PSB_ASSERT(a_count_step, o_valid && $past(o_valid) |-> o_result.binding_count == $past(o_result.binding_count) || o_result.binding_count == 5'($past(o_result.binding_count) + 5'd1) || o_result.binding_count == 5'($past(o_result.binding_count) - 5'd1), "binding count jumped")

endmodule

bind per_thread_stream_pool_binder psb_checker u_psb_checker (.*);
